>>> src/rv64m_multiply_divide_unit_core_defines.svh
// Assertion helpers used by the file that checks the design.
`ifndef RV64M_MULTIPLY_DIVIDE_UNIT_CORE_DEFINES_SVH
`define RV64M_MULTIPLY_DIVIDE_UNIT_CORE_DEFINES_SVH

`define MDU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MDU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/mdu_pkg.sv
package mdu_pkg;

    localparam int unsigned KindWidth = 4;
    localparam int unsigned XLen      = 64;
    localparam int unsigned RegWidth  = 5;
    localparam int unsigned QueueDepthDefault = 4;

    typedef enum logic [KindWidth-1:0] {
        K_MUL    = 4'd0,
        K_MULH   = 4'd1,
        K_MULHU  = 4'd2,
        K_MULHSU = 4'd3,
        K_DIV    = 4'd4,
        K_DIVU   = 4'd5,
        K_REM    = 4'd6,
        K_REMU   = 4'd7,
        K_MULW   = 4'd8,
        K_DIVW   = 4'd9,
        K_REMW   = 4'd10,
        K_DIVUW  = 4'd11,
        K_REMUW  = 4'd12
    } t_kind;

    typedef enum logic [1:0] {
        C_NONE = 2'd0,
        C_MUL  = 2'd1,
        C_DIV  = 2'd2
    } t_class;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MUL  = 2'd1,
        S_DIV  = 2'd2,
        S_DONE = 2'd3
    } t_state;

    typedef struct packed {
        t_class               op_class;
        logic                 sign_a;
        logic                 sign_b;
        logic                 high;
        logic                 rem;
        logic                 word;
        logic [XLen-1:0]      a;
        logic [XLen-1:0]      b;
        logic [RegWidth-1:0]  rd;
    } t_uop;

endpackage

>>> src/mdu_stream_if.sv
interface mdu_stream_if #(
    parameter int unsigned Width = 1
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/mdu_front.sv
module mdu_front (
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [mdu_pkg::KindWidth-1:0] i_kind,
    input  logic [mdu_pkg::XLen-1:0]      i_a,
    input  logic [mdu_pkg::XLen-1:0]      i_b,
    input  logic [mdu_pkg::RegWidth-1:0]  i_rd,
    mdu_stream_if.source            q_in
);
    import mdu_pkg::*;

    t_uop   w_uop;
    logic [XLen-1:0] w_a32;
    logic [XLen-1:0] w_b32;
    logic [XLen-1:0] w_az;
    logic [XLen-1:0] w_bz;

    assign w_a32 = {{32{i_a[31]}}, i_a[31:0]};
    assign w_b32 = {{32{i_b[31]}}, i_b[31:0]};
    assign w_az  = {32'd0, i_a[31:0]};
    assign w_bz  = {32'd0, i_b[31:0]};

    always_comb begin
        w_uop          = '0;
        w_uop.op_class = C_NONE;
        w_uop.a        = i_a;
        w_uop.b        = i_b;
        w_uop.rd       = i_rd;
        unique case (i_kind)
            K_MUL: begin
                w_uop.op_class = C_MUL;
            end
            K_MULH: begin
                w_uop.op_class = C_MUL;
                w_uop.high = 1'b1;
                w_uop.sign_a = 1'b1;
                w_uop.sign_b = 1'b1;
            end
            K_MULHU: begin
                w_uop.op_class = C_MUL;
                w_uop.high = 1'b1;
            end
            K_MULHSU: begin
                w_uop.op_class = C_MUL;
                w_uop.high = 1'b1;
                w_uop.sign_a = 1'b1;
            end
            K_MULW: begin
                w_uop.op_class = C_MUL;
                w_uop.word = 1'b1;
            end
            K_DIV, K_REM: begin
                w_uop.op_class = C_DIV;
                w_uop.sign_a = 1'b1;
                w_uop.sign_b = 1'b1;
                w_uop.rem = (i_kind == K_REM);
            end
            K_DIVU, K_REMU: begin
                w_uop.op_class = C_DIV;
                w_uop.rem = (i_kind == K_REMU);
            end
            K_DIVW, K_REMW: begin
                w_uop.op_class = C_DIV;
                w_uop.sign_a = 1'b1;
                w_uop.sign_b = 1'b1;
                w_uop.word = 1'b1;
                w_uop.rem = (i_kind == K_REMW);
                w_uop.a = w_a32;
                w_uop.b = w_b32;
            end
            K_DIVUW, K_REMUW: begin
                w_uop.op_class = C_DIV;
                w_uop.word = 1'b1;
                w_uop.rem = (i_kind == K_REMUW);
                w_uop.a = w_az;
                w_uop.b = w_bz;
            end
            default: begin
                w_uop.op_class = C_NONE;
            end
        endcase
    end

    assign q_in.valid = i_valid;
    assign q_in.data  = w_uop;
    assign o_ready    = q_in.ready;

endmodule

>>> src/mdu_queue.sv
module mdu_queue #(
    parameter int unsigned Depth = mdu_pkg::QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mdu_stream_if.sink   s,
    mdu_stream_if.source m
);
    import mdu_pkg::*;

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    t_uop            r_mem [Depth];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            w_push, w_pop;

    assign s.ready = (r_cnt != AW'(0) + (AW+1)'(Depth));
    assign m.valid = (r_cnt != '0);
    assign m.data  = r_mem[r_rp];
    assign w_push  = s.valid && s.ready;
    assign w_pop   = m.valid && m.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= s.data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

endmodule

>>> src/mdu_back.sv
module mdu_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mdu_stream_if.sink                   q_out,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mdu_pkg::XLen-1:0]     o_result,
    output logic [mdu_pkg::RegWidth-1:0] o_rd
);
    import mdu_pkg::*;

    t_uop            w_u;
    t_state          r_state, n_state;
    t_uop            r_u;
    logic [1:0]      r_step;
    logic [6:0]      r_cnt;
    logic [127:0]    r_acc;
    logic [63:0]     r_q, r_r, r_d, r_n;
    logic            r_neg_q, r_neg_r;
    logic [63:0]     w_res;
    logic [65:0]     w_sub;
    logic [64:0]     w_rsh;
    logic            w_take;
    logic [63:0]     w_hi_fix;
    logic [31:0]     w_sel_a, w_sel_b;

    assign w_u    = t_uop'(q_out.data);
    assign w_take = (r_state == S_IDLE) && q_out.valid;
    assign q_out.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (q_out.valid) begin
                    unique case (w_u.op_class)
                        C_MUL:   n_state = S_MUL;
                        C_DIV:   n_state = S_DIV;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_MUL: if (r_step == 2'd3) n_state = S_DONE;
            S_DIV: if (r_cnt == 7'd64) n_state = S_DONE;
            S_DONE: if (!o_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign w_rsh = {r_r, r_n[63]};
    assign w_sub = {1'b0, w_rsh} - {2'b0, r_d};

    assign w_sel_a = (r_step[1]) ? r_u.a[63:32] : r_u.a[31:0];
    assign w_sel_b = (r_step[0]) ? r_u.b[63:32] : r_u.b[31:0];

    always_comb begin
        w_hi_fix = r_acc[127:64];
        if (r_u.sign_a && r_u.a[63]) w_hi_fix = w_hi_fix - r_u.b;
        if (r_u.sign_b && r_u.b[63]) w_hi_fix = w_hi_fix - r_u.a;
        w_res = '0;
        if (r_u.op_class == C_MUL) begin
            if (r_u.word) w_res = {{32{r_acc[31]}}, r_acc[31:0]};
            else if (r_u.high) w_res = w_hi_fix;
            else w_res = r_acc[63:0];
        end else if (r_u.op_class == C_DIV) begin
            if (r_u.b == '0) begin
                w_res = r_u.rem ? r_u.a : '1;
            end else if (r_u.rem) begin
                w_res = r_neg_r ? (64'd0 - r_r) : r_r;
            end else begin
                w_res = r_neg_q ? (64'd0 - r_q) : r_q;
            end
            if (r_u.word) w_res = {{32{w_res[31]}}, w_res[31:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_step  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && n_state == S_IDLE) begin
                o_valid  <= 1'b1;
                o_result <= w_res;
                o_rd     <= r_u.rd;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            if (w_take) begin
                r_u    <= w_u;
                r_step <= '0;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_neg_r <= w_u.sign_a && w_u.a[63];
                r_neg_q <= w_u.sign_a && (w_u.a[63] ^ w_u.b[63]);
                r_n    <= (w_u.sign_a && w_u.a[63]) ? 64'd0 - w_u.a : w_u.a;
                r_d    <= (w_u.sign_b && w_u.b[63]) ? 64'd0 - w_u.b : w_u.b;
                r_r    <= '0;
                r_q    <= '0;
            end
            if (r_state == S_MUL) begin
                r_step <= r_step + 2'd1;
                r_acc  <= r_acc + ({64'd0, 64'(w_sel_a) * 64'(w_sel_b)}
                          << {{1'b0, r_step[1]} + {1'b0, r_step[0]}, 5'd0});
            end
            if (r_state == S_DIV && r_cnt != 7'd64) begin
                r_cnt <= r_cnt + 7'd1;
                r_n   <= {r_n[62:0], 1'b0};
                if (!w_sub[65]) begin
                    r_r <= w_sub[63:0];
                    r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_r <= w_rsh[63:0];
                    r_q <= {r_q[62:0], 1'b0};
                end
            end
        end
    end

endmodule

>>> src/rv64m_multiply_divide_unit_core.sv
// Channel   Dir  Payload
// in        in   kind, operand_a, operand_b, dest_reg
// out       out  result, result_reg
// Multiplies form four 32x32 partial products on one multiplier.
// Divides produce one quotient bit per cycle in the radix-2 divider.
// A queue lets the front accept while the back works.
// Reset is synchronous and active low; the output holds while i_ready is low.
`include "rv64m_multiply_divide_unit_core_defines.svh"
module rv64m_multiply_divide_unit_core #(
    parameter int unsigned QueueDepth = mdu_pkg::QueueDepthDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [mdu_pkg::KindWidth-1:0] i_kind,
    input  logic [mdu_pkg::XLen-1:0]     i_operand_a,
    input  logic [mdu_pkg::XLen-1:0]     i_operand_b,
    input  logic [mdu_pkg::RegWidth-1:0] i_dest_reg,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mdu_pkg::XLen-1:0]     o_result,
    output logic [mdu_pkg::RegWidth-1:0] o_result_reg
);
    import mdu_pkg::*;

    mdu_stream_if #(.Width($bits(t_uop))) q_in ();
    mdu_stream_if #(.Width($bits(t_uop))) q_out ();

    mdu_front u_front (
        .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_a(i_operand_a), .i_b(i_operand_b), .i_rd(i_dest_reg),
        .q_in(q_in.source)
    );

    mdu_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s(q_in.sink), .m(q_out.source)
    );

    mdu_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .q_out(q_out.sink),
        .o_valid(o_valid), .i_ready(i_ready), .o_result(o_result), .o_rd(o_result_reg)
    );

    `MDU_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid, "output dropped")
    `MDU_ASSERT_ALWAYS(a_reset_idle, i_clk, (!i_rst_n) |=> !o_valid, "valid after reset")

endmodule
